/* rtl/core/tbrb_pkg.sv */
// Shared constants, types and helpers for the trace byte ring buffer.
package tbrb_pkg;

  localparam int BufferDepth = 1024;
  localparam int PosW        = $clog2(BufferDepth);
  localparam int CntW        = $clog2(BufferDepth + 1);
  localparam int MaxResults  = 64;
  localparam int TakeW       = $clog2(MaxResults);
  localparam int CfgW        = 7;
  localparam logic [CfgW-1:0] CfgReset = CfgW'(MaxResults);

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_DRAIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLAG,
    ST_BYTE
  } state_e;

  typedef struct packed {
    logic do_put;
    logic do_enable;
    logic do_disable;
    logic do_drain;
    logic rd_issue;
    logic sel_byte;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } status_t;

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
    logic [PosW-1:0] r;
    if (p == PosW'(BufferDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/core/trace_byte_ring_buffer.sv */
// Top level of the trace byte ring buffer: controller, datapath and checks.
//
// Usage: commands enter on the s_axis channel, one per beat. tdata[1:0]
// carries the op (put, enable, disable, drain) and tdata[9:2] the byte to
// store. Puts, enables and disables produce no output, so they can be issued
// back to back. A drain is answered on the m_axis channel: first a flag beat
// (tuser high, overflow in tdata bit 0), then up to max_payload - 1 stored
// bytes (at most 63), oldest first; tlast marks the final beat. The flag beat
// is valid the cycle after the drain is accepted, and one byte follows per
// cycle while tready is high, since each byte read from the single-port store
// is issued as the previous beat leaves. A drain therefore holds the input
// until its final beat leaves, including any receiver stall; s_axis_tready is
// low for that whole time.
// While the receiver stalls, the current beat holds unchanged. Reset empties
// the ring, clears overflow, turns logging off and sets max_payload to 64;
// the byte store itself is not cleared. max_payload is written through cfg_we_i /
// cfg_wdata_i; the user must do so only while idle, as the block does not enforce it.
module trace_byte_ring_buffer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,   // [1:0] op, [9:2] char_in, rest zero
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] data_out
  output logic                      m_axis_tuser,   // [0] is_flag_byte
  output logic                      m_axis_tlast,
  input  logic                      cfg_we_i,
  input  logic [tbrb_pkg::CfgW-1:0] cfg_wdata_i
);

  tbrb_pkg::cmd_t    cmd;
  tbrb_pkg::status_t status;

  tbrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tdata[1:0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbrb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_i      (s_axis_tdata[9:2]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata),
    .out_flag_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // input is never taken while a drain is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while output beat pending");

  // every drain response opens with the flag beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> m_axis_tuser)
    else $error("drain response does not start with flag beat");

  // the final beat closes the response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output continues after last beat");

  // store reads happen only inside a drain, never with the byte count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_issue |-> (m_axis_tvalid && !status.count_zero))
    else $error("store read outside an active drain");

endmodule

/* rtl/core/tbrb_ctrl.sv */
// Control state machine: input acceptance and drain sequencing.
module tbrb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tbrb_pkg::status_t  status_i,
  output tbrb_pkg::cmd_t     cmd_o
);

  tbrb_pkg::state_e state_q, state_d;
  tbrb_pkg::op_e    op;
  logic             accept;

  assign op     = tbrb_pkg::op_e'(in_op_i);
  assign accept = in_valid_i && (state_q == tbrb_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbrb_pkg::ST_IDLE: begin
        if (accept && op == tbrb_pkg::OP_DRAIN) begin
          state_d = tbrb_pkg::ST_FLAG;
        end
      end
      tbrb_pkg::ST_FLAG: begin
        if (out_ready_i) begin
          state_d = status_i.count_zero ? tbrb_pkg::ST_IDLE : tbrb_pkg::ST_BYTE;
        end
      end
      tbrb_pkg::ST_BYTE: begin
        if (out_ready_i && status_i.count_zero) begin
          state_d = tbrb_pkg::ST_IDLE;
        end
      end
      default: state_d = tbrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o            = '0;
    cmd_o.do_put     = accept && op == tbrb_pkg::OP_PUT;
    cmd_o.do_enable  = accept && op == tbrb_pkg::OP_ENABLE;
    cmd_o.do_disable = accept && op == tbrb_pkg::OP_DISABLE;
    cmd_o.do_drain   = accept && op == tbrb_pkg::OP_DRAIN;
    case (state_q)
      tbrb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      tbrb_pkg::ST_FLAG: begin
        out_valid_o    = 1'b1;
        // fetch the next byte as the current beat leaves
        cmd_o.rd_issue = out_ready_i && !status_i.count_zero;
      end
      tbrb_pkg::ST_BYTE: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_byte = 1'b1;
        cmd_o.rd_issue = out_ready_i && !status_i.count_zero;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbrb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/tbrb_dp.sv */
// Datapath: byte store, ring pointers, flags and output beat registers.
module tbrb_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tbrb_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic [7:0]                  char_i,
  input  tbrb_pkg::cmd_t              cmd_i,
  output tbrb_pkg::status_t           status_o,
  output logic [7:0]                  out_data_o,
  output logic                        out_flag_o,
  output logic                        out_last_o
);

  localparam int PosW  = tbrb_pkg::PosW;
  localparam int CntW  = tbrb_pkg::CntW;
  localparam int TakeW = tbrb_pkg::TakeW;
  localparam int CfgW  = tbrb_pkg::CfgW;

  logic [7:0]       mem_q [tbrb_pkg::BufferDepth];
  logic [7:0]       rdata_q;
  logic [PosW-1:0]  wp_q, rp_q;
  logic             empty_q, overflow_q, logging_q;
  logic [CfgW-1:0]  max_payload_q;
  logic [TakeW-1:0] count_q;
  logic             flag_ovf_q, flag_last_q;

  logic             full;
  logic             write_ok;
  logic [CntW-1:0]  avail;
  logic [TakeW-1:0] limit_m1;
  logic [TakeW-1:0] take;
  logic             take_all;

  assign full     = !empty_q && (wp_q == rp_q);
  assign write_ok = cmd_i.do_put && logging_q && !full;

  always_comb begin
    if (empty_q) begin
      avail = '0;
    end else if (wp_q == rp_q) begin
      avail = CntW'(tbrb_pkg::BufferDepth);
    end else if (wp_q > rp_q) begin
      avail = CntW'(wp_q) - CntW'(rp_q);
    end else begin
      avail = CntW'(wp_q) + CntW'(tbrb_pkg::BufferDepth) - CntW'(rp_q);
    end
  end

  // clamp the payload limit, one slot goes to the flag byte
  always_comb begin
    if (max_payload_q == '0) begin
      limit_m1 = '0;
    end else if (max_payload_q >= CfgW'(tbrb_pkg::MaxResults)) begin
      limit_m1 = TakeW'(tbrb_pkg::MaxResults - 1);
    end else begin
      limit_m1 = TakeW'(max_payload_q - 1'b1);
    end
  end

  assign take_all = avail <= CntW'(limit_m1);
  assign take     = take_all ? TakeW'(avail) : limit_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q          <= '0;
      rp_q          <= '0;
      empty_q       <= 1'b1;
      overflow_q    <= 1'b0;
      logging_q     <= 1'b0;
      max_payload_q <= tbrb_pkg::CfgReset;
      count_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        max_payload_q <= cfg_wdata_i;
      end
      if (cmd_i.do_put && logging_q) begin
        if (full) begin
          overflow_q <= 1'b1;
        end else begin
          if (empty_q) begin
            rp_q    <= wp_q;
            empty_q <= 1'b0;
          end
          wp_q <= tbrb_pkg::next_pos(wp_q);
        end
      end
      if ((cmd_i.do_enable && !logging_q) || (cmd_i.do_disable && logging_q)) begin
        logging_q  <= cmd_i.do_enable;
        wp_q       <= '0;
        rp_q       <= '0;
        empty_q    <= 1'b1;
        overflow_q <= 1'b0;
      end
      if (cmd_i.do_drain) begin
        count_q    <= take;
        overflow_q <= 1'b0;
        if (take_all) begin
          empty_q <= 1'b1;
        end
      end
      if (cmd_i.rd_issue) begin
        rp_q    <= tbrb_pkg::next_pos(rp_q);
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_ok) begin
      mem_q[wp_q] <= char_i;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  // flag beat payload, loaded as the drain is accepted
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_drain) begin
      flag_ovf_q  <= overflow_q;
      flag_last_q <= (take == '0);
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign out_data_o = cmd_i.sel_byte ? rdata_q : {7'b0, flag_ovf_q};
  assign out_flag_o = !cmd_i.sel_byte;
  assign out_last_o = cmd_i.sel_byte ? status_o.count_zero : flag_last_q;

endmodule

/* sim/trace_byte_ring_buffer_tb.sv */
`timescale 1ns / 1ps
// Testbench for the trace byte ring buffer: command streams checked beat by beat against a local ring model.
module trace_byte_ring_buffer_tb;

  localparam int BufferDepth  = tbrb_pkg::BufferDepth;
  localparam int PosW         = tbrb_pkg::PosW;
  localparam int CfgW         = tbrb_pkg::CfgW;
  localparam int MaxResults   = tbrb_pkg::MaxResults;
  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 8;
  localparam int LongHold     = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       flag;
    logic       last;
  } beat_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata  = '0;  // [1:0] op, [9:2] char_in
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;        // [7:0] data_out
  logic            m_axis_tuser;        // [0] is_flag_byte
  logic            m_axis_tlast;
  logic            cfg_we_i      = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i   = '0;

  trace_byte_ring_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ring model state
  logic [7:0]      ring_mem [BufferDepth];
  logic [PosW-1:0] wr_pos      = '0;
  logic [PosW-1:0] rd_pos      = '0;
  logic            ring_empty  = 1'b1;
  logic            ovf_seen    = 1'b0;
  logic            log_on      = 1'b0;
  logic [CfgW-1:0] payload_cfg = tbrb_pkg::CfgReset;

  beat_t expected_beats [$];
  int    mismatches  = 0;
  int    quiet_count = 0;
  bit    tx_idle_on  = 1'b0;
  bit    rx_idle_on  = 1'b0;
  int    rx_hold_req = 0;

  function automatic logic [PosW-1:0] ring_advance(input logic [PosW-1:0] p);
    return PosW'((int'(p) + 1) % BufferDepth);
  endfunction

  function automatic int unsigned ring_fill();
    if (ring_empty) return 0;
    if (wr_pos == rd_pos) return BufferDepth;
    return (int'(wr_pos) + BufferDepth - int'(rd_pos)) % BufferDepth;
  endfunction

  function automatic void clear_ring();
    wr_pos     = '0;
    rd_pos     = '0;
    ring_empty = 1'b1;
    ovf_seen   = 1'b0;
  endfunction

  // Apply one accepted command to the ring model and queue the beats it causes.
  function automatic void predict_command(input tbrb_pkg::op_e op, input logic [7:0] ch);
    int unsigned lim;
    int unsigned avail;
    int unsigned take;
    beat_t       b;
    case (op)
      tbrb_pkg::OP_PUT: begin
        if (log_on) begin
          if (!ring_empty && wr_pos == rd_pos) begin
            ovf_seen = 1'b1;
          end else begin
            ring_mem[wr_pos] = ch;
            if (ring_empty) begin
              rd_pos     = wr_pos;
              ring_empty = 1'b0;
            end
            wr_pos = ring_advance(wr_pos);
          end
        end
      end
      tbrb_pkg::OP_ENABLE: begin
        if (!log_on) begin
          log_on = 1'b1;
          clear_ring();
        end
      end
      tbrb_pkg::OP_DISABLE: begin
        if (log_on) begin
          log_on = 1'b0;
          clear_ring();
        end
      end
      default: begin
        lim = payload_cfg;
        if (lim < 1) lim = 1;
        if (lim > MaxResults) lim = MaxResults;
        avail = ring_fill();
        take  = lim - 1;
        if (take > avail) take = avail;
        b.data = {7'd0, ovf_seen};
        b.flag = 1'b1;
        b.last = (take == 0);
        expected_beats.push_back(b);
        ovf_seen = 1'b0;
        for (int unsigned i = 0; i < take; i++) begin
          b.data = ring_mem[rd_pos];
          b.flag = 1'b0;
          b.last = (i + 1 == take);
          expected_beats.push_back(b);
          rd_pos = ring_advance(rd_pos);
        end
        if (take == avail) ring_empty = 1'b1;
      end
    endcase
  endfunction

  // Compare each output beat against the oldest expectation.
  always @(posedge clk_i) begin
    beat_t exp_b;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: data %0h flag %0b last %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (m_axis_tdata !== exp_b.data) begin
          $error("data_out mismatch: expected %0h, got %0h", exp_b.data, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== exp_b.flag) begin
          $error("is_flag_byte mismatch: expected %0b, got %0b", exp_b.flag, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== exp_b.last) begin
          $error("last mismatch: expected %0b, got %0b", exp_b.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Stop the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      n = 0;
      if (rx_hold_req > 0) begin
        n           = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input tbrb_pkg::op_e op, input logic [7:0] ch);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, ch, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_command(op, ch);
  endtask

  task automatic send_random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      send_cmd(tbrb_pkg::OP_PUT, 8'($urandom));
    end else if (r < 85) begin
      send_cmd(tbrb_pkg::OP_DRAIN, 8'($urandom));
    end else if (r < 96) begin
      send_cmd(tbrb_pkg::OP_ENABLE, 8'($urandom));
    end else begin
      send_cmd(tbrb_pkg::OP_DISABLE, 8'($urandom));
    end
  endtask

  // Drop valid, let every expected beat arrive, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_payload(input logic [CfgW-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    payload_cfg = v;
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);    // empty drain while disabled
    send_cmd(tbrb_pkg::OP_PUT, 8'h3C);      // dropped, logging off
    send_cmd(tbrb_pkg::OP_DISABLE, 8'h00);  // already off
    send_cmd(tbrb_pkg::OP_ENABLE, 8'hFF);
    send_cmd(tbrb_pkg::OP_ENABLE, 8'h00);   // already on
    send_cmd(tbrb_pkg::OP_PUT, 8'h00);
    send_cmd(tbrb_pkg::OP_PUT, 8'hFF);
    send_cmd(tbrb_pkg::OP_PUT, 8'hA5);
    send_cmd(tbrb_pkg::OP_PUT, 8'h5A);
    send_cmd(tbrb_pkg::OP_DRAIN, 8'hC3);
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
    send_cmd(tbrb_pkg::OP_PUT, 8'h81);
    send_cmd(tbrb_pkg::OP_DISABLE, 8'h00);  // clears the pending byte
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
    send_cmd(tbrb_pkg::OP_ENABLE, 8'h00);
    send_cmd(tbrb_pkg::OP_PUT, 8'h7E);
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
  endtask

  // Move the read position off zero with a first drain, then fill the ring, overflow it, and drain again.
  task automatic test_full_wrap();
    set_payload(7'd64);
    send_cmd(tbrb_pkg::OP_DISABLE, 8'h00);
    send_cmd(tbrb_pkg::OP_ENABLE, 8'h00);
    repeat (40) send_cmd(tbrb_pkg::OP_PUT, 8'($urandom));
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
    repeat (BufferDepth + 2) send_cmd(tbrb_pkg::OP_PUT, 8'($urandom));
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
  endtask

  // Drain the rest of the full ring at each payload limit, across the wrap.
  task automatic test_payload_limits();
    logic [CfgW-1:0] sizes [7] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd63, 7'd64};
    foreach (sizes[k]) begin
      set_payload(sizes[k]);
      send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
      send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
    end
    repeat (10) send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      set_payload(7'($urandom_range(0, 127)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_cmd(tbrb_pkg::OP_ENABLE, 8'h00);
      repeat (30) send_random_cmd();
    end
  endtask

  // Stall the receiver for a long stretch while commands keep coming.
  task automatic test_backpressure();
    set_payload(7'd64);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_cmd(tbrb_pkg::OP_DISABLE, 8'h00);
    send_cmd(tbrb_pkg::OP_ENABLE, 8'h00);
    repeat (60) send_cmd(tbrb_pkg::OP_PUT, 8'($urandom));
    rx_hold_req = LongHold;
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
    repeat (10) send_cmd(tbrb_pkg::OP_PUT, 8'($urandom));
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
  endtask

  task automatic test_no_idle();
    set_payload(7'($urandom_range(8, 64)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_cmd(tbrb_pkg::OP_ENABLE, 8'h00);
    repeat (30) send_random_cmd();
    send_cmd(tbrb_pkg::OP_DRAIN, 8'h00);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_wrap();
    test_payload_limits();
    test_random();
    test_backpressure();
    test_no_idle();
    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tbrb_pkg.sv
rtl/core/tbrb_ctrl.sv
rtl/core/tbrb_dp.sv
rtl/core/trace_byte_ring_buffer.sv
sim/trace_byte_ring_buffer_tb.sv
